/* src/tag_pkg.sv */
package tag_pkg;

    // Fixed field widths.
    localparam int ELEM_BITS    = 64;
    localparam int ADDR_BITS    = 32;
    localparam int DIM_BITS     = 16;
    localparam int STATUS_W     = 3;
    localparam int OUT_DATA_W   = ADDR_BITS + ELEM_BITS;

    // Configuration port.
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_DIMS     = 4;
    localparam int ORDER_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_LEN_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_LEN_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_LEN_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_LEN_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MAP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ORDER = 3'd6;

    // Default of the dimension count parameter.
    localparam int DEF_MAX_DIMS = 4;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH  = 2;

    // Command codes.
    localparam logic CMD_ELEM = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ARRAY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    // One classified input item.
    typedef struct packed {
        logic                 is_elem;
        logic [ELEM_BITS-1:0] data;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_BITS-1:0] dest_index;
        logic [ELEM_BITS-1:0] data_out;
        logic                 last;
    } t_result;

    // Handshake from the queue toward the back.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

endpackage

/* src/tag_front.sv */
module tag_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // element_data
    input  logic [tag_pkg::ELEM_BITS-1:0] s_axis_tdata,
    // cmd
    input  logic [0:0]                 s_axis_tuser,
    output logic                       o_valid,
    output tag_pkg::t_item             o_item,
    input  logic                       i_ready
);
    import tag_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The stage takes a new item whenever it is empty or drains this cycle.
    assign s_axis_tready = !r_valid || i_ready;
    assign o_valid       = r_valid;
    assign o_item        = r_item;

    // Register the item and tag it as a begin or an element command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_item  <= '0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_valid        <= 1'b1;
            r_item.is_elem <= (s_axis_tuser[0] == CMD_ELEM);
            r_item.data    <= s_axis_tdata;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

/* src/tag_queue.sv */
module tag_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tag_pkg::t_item      i_item,
    output logic                o_ready,
    output tag_pkg::t_queue_out o_head,
    input  logic                i_pop
);
    import tag_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_ready     = (r_count != CW'(QUEUE_DEPTH));
    assign push        = i_push && o_ready;
    assign pop         = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    // Pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* src/tag_back.sv */
module tag_back #(
    parameter int MAX_DIMS = tag_pkg::DEF_MAX_DIMS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tag_pkg::t_queue_out           i_head,
    output logic                          o_pop,
    input  logic                          i_cfg_we,
    input  logic [tag_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [tag_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_valid,
    output tag_pkg::t_result              o_result,
    input  logic                          i_ready
);
    import tag_pkg::*;

    localparam int IW = $clog2(MAX_DIMS);
    localparam int NW = $clog2(MAX_DIMS + 1);
    localparam int PW = ADDR_BITS + DIM_BITS;

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PROD    = 3'd1;
    localparam logic [2:0] S_CHECK   = 3'd2;
    localparam logic [2:0] S_STRIDE  = 3'd3;
    localparam logic [2:0] S_CARRY_A = 3'd4;
    localparam logic [2:0] S_CARRY_B = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    // Configuration registers.
    logic [2:0]          r_num_dims;
    logic [DIM_BITS-1:0] r_dim_len [CFG_DIMS];
    logic [ORDER_W-1:0]  r_order_map;
    logic                r_use_order;

    // Array state.
    logic [2:0]           r_state;
    logic [ADDR_BITS-1:0] r_stride [MAX_DIMS];
    logic [DIM_BITS-1:0]  r_digit  [MAX_DIMS];
    logic [ADDR_BITS-1:0] r_run;
    logic [ADDR_BITS-1:0] r_done;
    logic [ADDR_BITS-1:0] r_total;
    logic                 r_ready;
    logic                 r_ident;

    // Sequencer working registers.
    logic [IW-1:0]        r_idx;
    logic [ADDR_BITS-1:0] r_acc;
    logic                 r_zero;
    logic                 r_over;
    logic [IW-1:0]        r_inv [MAX_DIMS];
    logic [ADDR_BITS-1:0] r_mul;
    t_result              r_pend;
    t_result              r_out;
    logic                 r_out_valid;

    logic [NW-1:0]        n_use;
    logic                 out_free;
    logic                 out_load;
    logic [DIM_BITS-1:0]  prod_len;
    logic [DIM_BITS-1:0]  stride_len;
    logic [DIM_BITS-1:0]  car_len;
    logic [DIM_BITS-1:0]  len0;
    logic [ADDR_BITS-1:0] mul_a;
    logic [DIM_BITS-1:0]  mul_b;
    logic [PW-1:0]        mul_p;
    logic                 last_dim;
    logic [ADDR_BITS-1:0] prod_final;
    logic [STATUS_W-1:0]  chk_status;
    logic [3:0]           chk_seen;
    logic [1:0]           chk_pos;
    logic [IW-1:0]        chk_inv [MAX_DIMS];
    logic [ADDR_BITS-1:0] elem_idx;
    logic                 elem_last;
    logic [DIM_BITS-1:0]  digit0_next;
    logic                 carry0;
    logic                 carry_j;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign out_free = !r_out_valid || i_ready;

    // Dimension count in use, clamped to what the hardware holds.
    assign n_use = (r_num_dims > 3'(MAX_DIMS)) ? NW'(MAX_DIMS) : NW'(r_num_dims);

    // Length selections: digit j of the odometer runs over source dimension n-1-j.
    assign prod_len   = r_dim_len[r_idx];
    assign stride_len = r_dim_len[r_inv[r_idx]];
    assign car_len    = r_dim_len[IW'(n_use - NW'(1) - NW'(r_idx))];
    assign len0       = r_dim_len[IW'(n_use - NW'(1))];

    // One shared multiplier for size, stride and carry work.
    always_comb begin
        mul_a = r_acc;
        mul_b = prod_len;
        case (r_state)
            S_STRIDE: begin
                mul_b = stride_len;
            end
            S_CARRY_A: begin
                mul_a = r_stride[r_idx];
                mul_b = car_len;
            end
            default: begin
            end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign last_dim   = ((NW'(r_idx) + NW'(1)) == n_use);
    assign prod_final = r_zero ? '0 : r_acc;

    // Order map check: first entry out of range or already taken wins.
    always_comb begin
        chk_status = ST_OK;
        chk_seen   = '0;
        chk_pos    = '0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            chk_inv[i] = '0;
        end
        for (int i = 0; i < MAX_DIMS; i++) begin
            if ((NW'(i) < n_use) && (chk_status == ST_OK)) begin
                chk_pos = r_use_order ? r_order_map[2*i +: 2]
                                      : 2'(n_use - NW'(1) - NW'(i));
                if (3'(chk_pos) >= 3'(n_use)) begin
                    chk_status = ST_RANGE;
                end else if (chk_seen[chk_pos]) begin
                    chk_status = ST_DUP;
                end else begin
                    chk_seen[chk_pos]       = 1'b1;
                    chk_inv[chk_pos[IW-1:0]] = IW'(i);
                end
            end
        end
    end

    // Element result fields and the first odometer digit.
    assign elem_idx    = r_ident ? r_done : r_run;
    assign elem_last   = ((r_done + ADDR_BITS'(1)) == r_total);
    assign digit0_next = r_digit[0] + DIM_BITS'(1);
    assign carry0      = (n_use > NW'(1)) && (digit0_next == len0);
    assign carry_j     = ((NW'(r_idx) + NW'(1)) < n_use) && (r_digit[r_idx] == car_len);

    assign o_pop = (r_state == S_IDLE) && i_head.valid && (!i_head.item.is_elem || out_free);

    // A result is loaded when an element needs no carry work or a pending result leaves.
    assign out_load = (o_pop && i_head.item.is_elem
                       && (!r_ready || elem_last || r_ident || !carry0))
                   || ((r_state == S_EMIT) && out_free);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims  <= '0;
            r_order_map <= '0;
            r_use_order <= 1'b0;
            for (int i = 0; i < CFG_DIMS; i++) begin
                r_dim_len[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NUM_DIMS:  r_num_dims  <= i_cfg_data[2:0];
                CFG_DIM_LEN_0: r_dim_len[0] <= i_cfg_data[DIM_BITS-1:0];
                CFG_DIM_LEN_1: r_dim_len[1] <= i_cfg_data[DIM_BITS-1:0];
                CFG_DIM_LEN_2: r_dim_len[2] <= i_cfg_data[DIM_BITS-1:0];
                CFG_DIM_LEN_3: r_dim_len[3] <= i_cfg_data[DIM_BITS-1:0];
                CFG_ORDER_MAP: r_order_map <= i_cfg_data[ORDER_W-1:0];
                CFG_USE_ORDER: r_use_order <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer, array state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b0;
            r_ident     <= 1'b0;
            r_run       <= '0;
            r_done      <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_zero      <= 1'b0;
            r_over      <= 1'b0;
            r_mul       <= '0;
            r_pend      <= '0;
            r_out       <= '0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_stride[i] <= '0;
                r_digit[i]  <= '0;
                r_inv[i]    <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop && !i_head.item.is_elem) begin
                        // Begin: drop the old array and size the new one.
                        r_ready <= 1'b0;
                        r_ident <= 1'b0;
                        r_run   <= '0;
                        r_done  <= '0;
                        r_total <= '0;
                        for (int i = 0; i < MAX_DIMS; i++) begin
                            r_stride[i] <= '0;
                            r_digit[i]  <= '0;
                        end
                        r_pend  <= '0;
                        r_idx   <= '0;
                        r_acc   <= ADDR_BITS'(1);
                        r_zero  <= 1'b0;
                        r_over  <= 1'b0;
                        r_state <= (n_use == '0) ? S_CHECK : S_PROD;
                    end else if (o_pop) begin
                        // Element: report its index, then advance.
                        if (!r_ready) begin
                            r_out <= '{ST_NO_ARRAY, ADDR_BITS'(0), ELEM_BITS'(0), 1'b0};
                        end else begin
                            r_pend.status     <= ST_OK;
                            r_pend.dest_index <= elem_idx;
                            r_pend.data_out   <= i_head.item.data;
                            r_pend.last       <= elem_last;
                            r_out.status      <= ST_OK;
                            r_out.dest_index  <= elem_idx;
                            r_out.data_out    <= i_head.item.data;
                            r_out.last        <= elem_last;
                            if (elem_last) begin
                                r_ready     <= 1'b0;
                                r_done      <= r_total;
                            end else begin
                                r_done <= r_done + ADDR_BITS'(1);
                                if (!r_ident) begin
                                    r_run      <= r_run + r_stride[0];
                                    r_digit[0] <= digit0_next;
                                    if (carry0) begin
                                        r_idx   <= '0;
                                        r_state <= S_CARRY_A;
                                    end
                                end
                            end
                        end
                    end
                end
                S_PROD: begin
                    // Element count, one dimension a cycle.
                    if (prod_len == '0) begin
                        r_zero <= 1'b1;
                    end else if (!r_over) begin
                        if (mul_p[PW-1:ADDR_BITS] != '0) begin
                            r_over <= 1'b1;
                        end else begin
                            r_acc <= mul_p[ADDR_BITS-1:0];
                        end
                    end
                    if (last_dim) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_CHECK: begin
                    if (!r_zero && r_over) begin
                        r_pend.status <= ST_OVERFLOW;
                        r_state       <= S_EMIT;
                    end else begin
                        r_total <= prod_final;
                        if ((n_use <= NW'(1)) || (prod_final <= ADDR_BITS'(1))) begin
                            r_ident <= 1'b1;
                            r_ready <= (prod_final != '0);
                            r_state <= S_EMIT;
                        end else if (chk_status != ST_OK) begin
                            r_pend.status <= chk_status;
                            r_state       <= S_EMIT;
                        end else begin
                            r_inv   <= chk_inv;
                            r_idx   <= IW'(n_use - NW'(1));
                            r_acc   <= ADDR_BITS'(1);
                            r_state <= S_STRIDE;
                        end
                    end
                end
                S_STRIDE: begin
                    // Destination strides from the fastest destination dimension up.
                    r_stride[IW'(n_use - NW'(1) - NW'(r_inv[r_idx]))] <= r_acc;
                    r_acc <= mul_p[ADDR_BITS-1:0];
                    if (r_idx == '0) begin
                        r_ready <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx - IW'(1);
                    end
                end
                S_CARRY_A: begin
                    // Wrap digit j if it reached its length.
                    if (carry_j) begin
                        r_digit[r_idx] <= '0;
                        r_mul          <= mul_p[ADDR_BITS-1:0];
                        r_state        <= S_CARRY_B;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_CARRY_B: begin
                    // Undo the wrapped digit and step the next one.
                    r_run <= r_run - r_mul + r_stride[r_idx + IW'(1)];
                    r_digit[r_idx + IW'(1)] <= r_digit[r_idx + IW'(1)] + DIM_BITS'(1);
                    r_idx   <= r_idx + IW'(1);
                    r_state <= S_CARRY_A;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out       <= r_pend;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/transpose_address_generator.sv */
// An accepted item passes the front register and the queue before its result is registered.
// Throughput: one element per cycle while the output is free and the sequencer is idle; a carry
// into digit k adds a multiply and an update per wrapped digit, a final digit check and the
// output load. A begin sizes the array, checks the order map and computes the strides.
// Reset is synchronous and active low: control and state registers clear to zero and no
// array is open; the queue storage is not cleared.
module transpose_address_generator #(
    parameter int MAX_DIMS = tag_pkg::DEF_MAX_DIMS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // element_data
    input  logic [tag_pkg::ELEM_BITS-1:0]   s_axis_tdata,
    // cmd
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // dest_index [31:0], data_out [95:32]
    output logic [tag_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [tag_pkg::STATUS_W-1:0]    m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [tag_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [tag_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tag_pkg::*;

    logic       front_valid;
    t_item      front_item;
    logic       queue_ready;
    t_queue_out queue_head;
    logic       queue_pop;
    t_result    result;

    tag_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_valid       (front_valid),
        .o_item        (front_item),
        .i_ready       (queue_ready)
    );

    tag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_ready (queue_ready),
        .o_head  (queue_head),
        .i_pop   (queue_pop)
    );

    tag_back #(
        .MAX_DIMS (MAX_DIMS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (queue_head),
        .o_pop      (queue_pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_valid    (m_axis_tvalid),
        .o_result   (result),
        .i_ready    (m_axis_tready)
    );

    // Pack the result item onto the output stream.
    assign m_axis_tdata = {result.data_out, result.dest_index};
    assign m_axis_tuser = result.status;
    assign m_axis_tlast = result.last;

endmodule
